### rtl/core/tapat_pkg.sv
// tapat_pkg: types, codes and constants shared by the angle tracker files
// no dependencies
`default_nettype none

package tapat_pkg;

    localparam int ERR_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int ANGLE_W  = 17;
    localparam int CFG_D_W  = 17;
    localparam int CFG_I_W  = 3;
    localparam int SUM_W    = 32;
    localparam int MUL_A_W  = 17;
    localparam int MUL_B_W  = 32;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int STEP_W   = 18;
    localparam int NUM_STEPS = 10;
    localparam int PC_W     = $clog2(NUM_STEPS);

    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 17'd34560;

    localparam logic [CFG_I_W-1:0] REG_GAIN_PROP    = 3'd0;
    localparam logic [CFG_I_W-1:0] REG_GAIN_INTEG   = 3'd1;
    localparam logic [CFG_I_W-1:0] REG_GAIN_DERIV   = 3'd2;
    localparam logic [CFG_I_W-1:0] REG_MAX_STEP     = 3'd3;
    localparam logic [CFG_I_W-1:0] REG_SMOOTH_ALPHA = 3'd4;
    localparam logic [CFG_I_W-1:0] REG_BASE_MIN     = 3'd5;
    localparam logic [CFG_I_W-1:0] REG_BASE_MAX     = 3'd6;
    localparam logic [CFG_I_W-1:0] REG_ARM_MAX      = 3'd7;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_ALPHA_D,
        MUL_GP_F,
        MUL_GI_SUM,
        MUL_GD_DERIV
    } t_mul_sel;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_FILT,
        OP_INTEG,
        OP_STEP,
        OP_ANGLE,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     acc_clr;
        logic     acc_add;
        t_op      op;
        logic     jmp_first;
        t_pc      jmp_target;
    } t_ctrl;

    typedef struct packed {
        logic  run;
        logic  axis;
        t_ctrl cw;
    } t_seq_out;

    typedef struct packed {
        logic out_hold;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/tapat_ifs.sv
// tapat_ifs: valid/ready channels of the angle tracker (input, result, register write)
// depends on tapat_pkg
`default_nettype none

interface tapat_in_if
    import tapat_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic signed [ERR_W-1:0]  x_error;
    logic signed [ERR_W-1:0]  y_error;

    modport source (output valid, output x_error, output y_error, input ready);
    modport sink   (input valid, input x_error, input y_error, output ready);
endinterface

interface tapat_out_if
    import tapat_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic [ANGLE_W-1:0]   base_angle_out;
    logic [ANGLE_W-1:0]   arm_angle_out;

    modport source (output valid, output base_angle_out, output arm_angle_out, input ready);
    modport sink   (input valid, input base_angle_out, input arm_angle_out, output ready);
endinterface

interface tapat_cfg_if
    import tapat_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic [CFG_I_W-1:0]   index;
    logic [CFG_D_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/tapat_ucode_rom.sv
// tapat_ucode_rom: microprogram of one control tick, one control word per step
// depends on tapat_pkg
`default_nettype none

module tapat_ucode_rom
    import tapat_pkg::*;
(
    input  wire t_pc   i_pc,
    output t_ctrl      o_cw
);

    always_comb begin
        o_cw.mul_sel    = MUL_NONE;
        o_cw.acc_clr    = 1'b0;
        o_cw.acc_add    = 1'b0;
        o_cw.op         = OP_NOP;
        o_cw.jmp_first  = 1'b0;
        o_cw.jmp_target = '0;
        unique case (i_pc)
            t_pc'(0): begin
                o_cw.op      = OP_LOAD;
                o_cw.acc_clr = 1'b1;
            end
            t_pc'(1): begin
                o_cw.mul_sel = MUL_ALPHA_D;
            end
            t_pc'(2): begin
                o_cw.op = OP_FILT;
            end
            t_pc'(3): begin
                o_cw.op      = OP_INTEG;
                o_cw.mul_sel = MUL_GP_F;
            end
            t_pc'(4): begin
                o_cw.mul_sel = MUL_GI_SUM;
                o_cw.acc_add = 1'b1;
            end
            t_pc'(5): begin
                o_cw.mul_sel = MUL_GD_DERIV;
                o_cw.acc_add = 1'b1;
            end
            t_pc'(6): begin
                o_cw.acc_add = 1'b1;
            end
            t_pc'(7): begin
                o_cw.op = OP_STEP;
            end
            t_pc'(8): begin
                o_cw.op         = OP_ANGLE;
                o_cw.jmp_first  = 1'b1;
                o_cw.jmp_target = t_pc'(0);
            end
            t_pc'(9): begin
                o_cw.op = OP_DONE;
            end
            default: begin
                o_cw.op = OP_DONE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/tapat_sequencer.sv
// tapat_sequencer: step counter, axis select and jump logic over the microcode rom
// depends on tapat_pkg, tapat_ucode_rom
`default_nettype none

module tapat_sequencer
    import tapat_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire t_dp_stat  i_stat,
    output t_seq_out       o_seq,
    output logic           o_busy
);

    logic  r_busy, n_busy;
    logic  r_axis, n_axis;
    t_pc   r_pc, n_pc;
    t_ctrl cw;
    logic  run;

    tapat_ucode_rom u_rom (
        .i_pc (r_pc),
        .o_cw (cw)
    );

    assign run = r_busy && !((cw.op == OP_DONE) && i_stat.out_hold);

    always_comb begin
        n_busy = r_busy;
        n_axis = r_axis;
        n_pc   = r_pc;
        if (i_start) begin
            n_busy = 1'b1;
            n_axis = 1'b0;
            n_pc   = '0;
        end else if (run) begin
            if (cw.op == OP_DONE) begin
                n_busy = 1'b0;
                n_pc   = '0;
            end else if (cw.jmp_first && !r_axis) begin
                n_axis = 1'b1;
                n_pc   = cw.jmp_target;
            end else begin
                n_pc = r_pc + t_pc'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_axis <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_axis <= n_axis;
            r_pc   <= n_pc;
        end
    end

    assign o_seq.run  = run;
    assign o_seq.axis = r_axis;
    assign o_seq.cw   = cw;
    assign o_busy     = r_busy;

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= t_pc'(NUM_STEPS - 1)))
        else $error("step counter out of program");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("start while busy");
    a_start_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && (r_pc == '0) && !r_axis))
        else $error("tick does not start at step zero on the base axis");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && (cw.op == OP_DONE)) |-> r_axis)
        else $error("tick finished before the arm axis");
    a_done_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && (cw.op == OP_DONE)) |=> !r_busy)
        else $error("sequencer still busy after final step");
`endif

endmodule

`default_nettype wire

### rtl/core/tapat_datapath.sv
// tapat_datapath: config registers, axis state, shared multiplier, accumulator, output register
// depends on tapat_pkg
`default_nettype none

module tapat_datapath
    import tapat_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire [CFG_I_W-1:0]         i_cfg_index,
    input  wire [CFG_D_W-1:0]         i_cfg_data,
    input  wire                       i_start,
    input  wire signed [ERR_W-1:0]    i_x_error,
    input  wire signed [ERR_W-1:0]    i_y_error,
    input  wire t_seq_out             i_seq,
    input  wire                       i_out_ready,
    output logic                      o_out_valid,
    output logic [ANGLE_W-1:0]        o_base_angle,
    output logic [ANGLE_W-1:0]        o_arm_angle,
    output t_dp_stat                  o_stat
);

    // configuration
    logic signed [GAIN_W-1:0] r_gain_prop, r_gain_integ, r_gain_deriv;
    logic [GAIN_W-1:0]        r_max_step, r_alpha;
    logic [ANGLE_W-1:0]       r_base_min, r_base_max, r_arm_max;

    // per-axis state
    logic signed [ERR_W-1:0]  r_filt [2];
    logic signed [ERR_W-1:0]  r_prev [2];
    logic signed [SUM_W-1:0]  r_sum  [2];
    logic [ANGLE_W-1:0]       r_angle [2];

    // working registers
    logic signed [ERR_W-1:0]  r_x, r_y, r_e;
    logic signed [ERR_W:0]    r_deriv;
    logic signed [PROD_W-1:0] r_prod, r_acc;
    logic signed [STEP_W-1:0] r_step;
    logic                     r_out_valid;
    logic [ANGLE_W-1:0]       r_out_base, r_out_arm;

    logic                     ax;
    logic                     run;
    t_ctrl                    cw;
    logic signed [ERR_W-1:0]  f_cur, y_neg;
    logic signed [ERR_W:0]    d_err, deriv_new;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p, prod_rnd, acc_rnd, acc_sum;
    logic signed [STEP_W-1:0] filt_inc;
    logic signed [ERR_W+2:0]  filt_sum;
    logic signed [ERR_W-1:0]  filt_new;
    logic signed [SUM_W:0]    sum_ext;
    logic signed [SUM_W-1:0]  sum_new;
    logic signed [34:0]       step_raw, lim_pos, lim_neg;
    logic signed [STEP_W-1:0] step_new;
    logic signed [ANGLE_W+1:0] ang_sum, win_lo, win_hi;
    logic [ANGLE_W-1:0]       ang_new;
    logic                     out_hold;

    assign ax    = i_seq.axis;
    assign run   = i_seq.run;
    assign cw    = i_seq.cw;
    assign f_cur = r_filt[ax];

    // negated y saturates at the most positive code when y is the most negative code
    assign y_neg = (r_y == $signed({1'b1, {(ERR_W-1){1'b0}}})) ?
                   $signed({1'b0, {(ERR_W-1){1'b1}}}) : -r_y;

    assign d_err     = $signed({r_e[ERR_W-1], r_e}) - $signed({f_cur[ERR_W-1], f_cur});
    assign deriv_new = $signed({f_cur[ERR_W-1], f_cur}) -
                       $signed({r_prev[ax][ERR_W-1], r_prev[ax]});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cw.mul_sel)
            MUL_ALPHA_D: begin
                mul_a = $signed({1'b0, r_alpha});
                mul_b = $signed({{(MUL_B_W-ERR_W-1){d_err[ERR_W]}}, d_err});
            end
            MUL_GP_F: begin
                mul_a = $signed({r_gain_prop[GAIN_W-1], r_gain_prop});
                mul_b = $signed({{(MUL_B_W-ERR_W){f_cur[ERR_W-1]}}, f_cur});
            end
            MUL_GI_SUM: begin
                mul_a = $signed({r_gain_integ[GAIN_W-1], r_gain_integ});
                mul_b = r_sum[ax];
            end
            MUL_GD_DERIV: begin
                mul_a = $signed({r_gain_deriv[GAIN_W-1], r_gain_deriv});
                mul_b = $signed({{(MUL_B_W-ERR_W-1){r_deriv[ERR_W]}}, r_deriv});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // low-pass update, round half up by 2^16
    assign prod_rnd = r_prod + $signed(PROD_W'(32768));
    assign filt_inc = prod_rnd[16+STEP_W-1:16];
    assign filt_sum = $signed({{3{f_cur[ERR_W-1]}}, f_cur}) +
                      $signed({filt_inc[STEP_W-1], filt_inc});

    always_comb begin
        if (filt_sum > $signed((ERR_W+3)'(32767))) begin
            filt_new = $signed(ERR_W'(32767));
        end else if (filt_sum < -$signed((ERR_W+3)'(32768))) begin
            filt_new = $signed({1'b1, {(ERR_W-1){1'b0}}});
        end else begin
            filt_new = filt_sum[ERR_W-1:0];
        end
    end

    // integral with 32-bit saturation
    assign sum_ext = $signed({r_sum[ax][SUM_W-1], r_sum[ax]}) +
                     $signed({{(SUM_W-ERR_W+1){f_cur[ERR_W-1]}}, f_cur});

    always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_new = sum_ext[SUM_W] ? $signed({1'b1, {(SUM_W-1){1'b0}}})
                                     : $signed({1'b0, {(SUM_W-1){1'b1}}});
        end else begin
            sum_new = sum_ext[SUM_W-1:0];
        end
    end

    assign acc_sum = r_acc + r_prod;

    // step: round half up by 2^14, clamp to max_step
    assign acc_rnd  = r_acc + $signed(PROD_W'(8192));
    assign step_raw = acc_rnd[PROD_W-1:14];
    assign lim_pos  = $signed({19'd0, r_max_step});
    assign lim_neg  = -lim_pos;

    always_comb begin
        if (step_raw < lim_neg) begin
            step_new = lim_neg[STEP_W-1:0];
        end else if (step_raw > lim_pos) begin
            step_new = lim_pos[STEP_W-1:0];
        end else begin
            step_new = step_raw[STEP_W-1:0];
        end
    end

    // angle window, lower bound tested first
    assign ang_sum = $signed({1'b0, r_angle[ax]}) + $signed({r_step[STEP_W-1], r_step});
    assign win_lo  = ax ? '0 : $signed({2'b00, r_base_min});
    assign win_hi  = ax ? $signed({2'b00, r_arm_max}) : $signed({2'b00, r_base_max});

    always_comb begin
        if (ang_sum < win_lo) begin
            ang_new = win_lo[ANGLE_W-1:0];
        end else if (ang_sum > win_hi) begin
            ang_new = win_hi[ANGLE_W-1:0];
        end else begin
            ang_new = ang_sum[ANGLE_W-1:0];
        end
    end

    assign out_hold = r_out_valid && !i_out_ready;

    // configuration and axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= -16'sd205;
            r_gain_integ <= 16'sd0;
            r_gain_deriv <= -16'sd2816;
            r_max_step   <= 16'd2304;
            r_alpha      <= 16'd13107;
            r_base_min   <= 17'd16640;
            r_base_max   <= 17'd29440;
            r_arm_max    <= 17'd11520;
            for (int a = 0; a < 2; a++) begin
                r_filt[a]  <= '0;
                r_prev[a]  <= '0;
                r_sum[a]   <= '0;
                r_angle[a] <= ANGLE_RESET;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN_PROP:    r_gain_prop  <= i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_INTEG:   r_gain_integ <= i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_DERIV:   r_gain_deriv <= i_cfg_data[GAIN_W-1:0];
                    REG_MAX_STEP:     r_max_step   <= i_cfg_data[GAIN_W-1:0];
                    REG_SMOOTH_ALPHA: r_alpha      <= i_cfg_data[GAIN_W-1:0];
                    REG_BASE_MIN:     r_base_min   <= i_cfg_data;
                    REG_BASE_MAX:     r_base_max   <= i_cfg_data;
                    REG_ARM_MAX:      r_arm_max    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (run) begin
                case (cw.op)
                    OP_FILT: r_filt[ax] <= filt_new;
                    OP_INTEG: begin
                        r_sum[ax]  <= sum_new;
                        r_prev[ax] <= f_cur;
                    end
                    OP_ANGLE: r_angle[ax] <= ang_new;
                    default: ;
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x_error;
            r_y <= i_y_error;
        end
        if (run) begin
            r_prod <= mul_p;
            if (cw.acc_clr) begin
                r_acc <= '0;
            end else if (cw.acc_add) begin
                r_acc <= acc_sum;
            end
            case (cw.op)
                OP_LOAD:  r_e <= ax ? y_neg : r_x;
                OP_INTEG: r_deriv <= deriv_new;
                OP_STEP:  r_step <= step_new;
                OP_DONE: begin
                    r_out_base <= r_angle[0];
                    r_out_arm  <= r_angle[1];
                end
                default: ;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (run && (cw.op == OP_DONE)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_base_angle    = r_out_base;
    assign o_arm_angle     = r_out_arm;
    assign o_stat.out_hold = out_hold;

`ifndef SYNTHESIS
    a_done_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && (cw.op == OP_DONE)) |-> !out_hold)
        else $error("result overwrote a word not yet taken");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && (cw.op == OP_DONE)) |=> r_out_valid)
        else $error("result not presented after final step");
    a_arm_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && (cw.op == OP_ANGLE) && ax) |=> (r_angle[1] <= $past(r_arm_max)))
        else $error("arm angle left its window");
`endif

endmodule

`default_nettype wire

### rtl/core/two_axis_pid_angle_tracker.sv
// Each accepted error word runs through nine microcode steps per axis, base then arm, on
// one shared 17x32 multiplier and accumulator, plus one step that loads the output
// register, which then presents the result word. The next error word is accepted in the
// cycle after that last step. A new tick may run while the previous result still waits
// to be taken; it then holds at its last step, and the error input stays closed, until that
// result is taken. Register writes are accepted in any cycle and take effect at once, so
// they belong between ticks.
//
// two_axis_pid_angle_tracker: top level, wires the channels to the sequencer and datapath
// depends on tapat_pkg, tapat_ifs, tapat_sequencer, tapat_datapath
`default_nettype none

module two_axis_pid_angle_tracker
    import tapat_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    tapat_in_if.sink    i_in,
    tapat_out_if.source o_out,
    tapat_cfg_if.sink   i_cfg
);

    t_seq_out seq;
    t_dp_stat stat;
    logic     busy;
    logic     start;
    logic     cfg_we;

    assign i_in.ready  = !busy;
    assign start       = i_in.valid && !busy;
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    tapat_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_seq   (seq),
        .o_busy  (busy)
    );

    tapat_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_start      (start),
        .i_x_error    (i_in.x_error),
        .i_y_error    (i_in.y_error),
        .i_seq        (seq),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_base_angle (o_out.base_angle_out),
        .o_arm_angle  (o_out.arm_angle_out),
        .o_stat       (stat)
    );

endmodule

`default_nettype wire

### dv/two_axis_pid_angle_tracker_tb.sv
// two_axis_pid_angle_tracker_tb: checks every result word of the angle tracker against
// a mirror of its filter, PID and clamp arithmetic, over many register settings
// depends on tapat_pkg, tapat_ifs and the two_axis_pid_angle_tracker RTL
`timescale 1ns / 1ps

module two_axis_pid_angle_tracker_tb
    import tapat_pkg::*;
    ;

    localparam int RST_CYCLES      = 10;
    localparam int TICK_LATENCY    = 24;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RAND_PHASES     = 8;
    localparam int TICKS_PER_PHASE = 200;
    localparam int LONG_HOLD       = 400;

    typedef struct packed {
        logic [ANGLE_W-1:0] base;
        logic [ANGLE_W-1:0] arm;
    } t_angles;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [15:0]        max_step;
        logic [15:0]        alpha;
        logic [ANGLE_W-1:0] base_lo;
        logic [ANGLE_W-1:0] base_hi;
        logic [ANGLE_W-1:0] arm_hi;
    } t_settings;

    class tracker_mirror;
        logic signed [GAIN_W-1:0] kp, ki, kd;
        logic [15:0]              max_step, alpha;
        logic [ANGLE_W-1:0]       base_lo, base_hi, arm_hi;
        logic signed [ERR_W-1:0]  filt [2];
        logic signed [ERR_W-1:0]  prev [2];
        logic signed [SUM_W-1:0]  err_sum [2];
        logic [ANGLE_W-1:0]       angle [2];
        t_angles                  pending_angles [$];
        int                       checked;
        int                       errors;

        function void clear();
            kp       = -16'sd205;
            ki       = 16'sd0;
            kd       = -16'sd2816;
            max_step = 16'd2304;
            alpha    = 16'd13107;
            base_lo  = 17'd16640;
            base_hi  = 17'd29440;
            arm_hi   = 17'd11520;
            for (int a = 0; a < 2; a++) begin
                filt[a]    = '0;
                prev[a]    = '0;
                err_sum[a] = '0;
                angle[a]   = ANGLE_RESET;
            end
            pending_angles.delete();
            checked = 0;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_I_W-1:0] idx, logic [CFG_D_W-1:0] val);
            case (idx)
                REG_GAIN_PROP:    kp       = val[GAIN_W-1:0];
                REG_GAIN_INTEG:   ki       = val[GAIN_W-1:0];
                REG_GAIN_DERIV:   kd       = val[GAIN_W-1:0];
                REG_MAX_STEP:     max_step = val[15:0];
                REG_SMOOTH_ALPHA: alpha    = val[15:0];
                REG_BASE_MIN:     base_lo  = val;
                REG_BASE_MAX:     base_hi  = val;
                REG_ARM_MAX:      arm_hi   = val;
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // low-pass, pid and step clamp for one axis, returns the angle step
        function longint pid_step(int a, longint e);
            longint f, deriv, s, acc, stp, lim;
            f = longint'(filt[a]);
            f = clip(f + ((longint'(alpha) * (e - f) + 32768) >>> 16), -32768, 32767);
            deriv = f - longint'(prev[a]);
            s = clip(longint'(err_sum[a]) + f, -(longint'(1) <<< 31),
                     (longint'(1) <<< 31) - 1);
            filt[a]    = f[ERR_W-1:0];
            prev[a]    = f[ERR_W-1:0];
            err_sum[a] = s[SUM_W-1:0];
            acc = longint'(kp) * f + longint'(ki) * s + longint'(kd) * deriv;
            stp = (acc + 8192) >>> 14;
            lim = longint'(max_step);
            return clip(stp, -lim, lim);
        endfunction

        function void note_errors(logic signed [ERR_W-1:0] x, logic signed [ERR_W-1:0] y);
            longint ey, sb, sa, v;
            t_angles res;
            ey = -longint'(y);
            if (ey > 32767) ey = 32767;
            sb = pid_step(0, longint'(x));
            sa = pid_step(1, ey);
            // lower bound first; inverted window: base_lo if below it, else base_hi
            v = longint'(angle[0]) + sb;
            if (v < longint'(base_lo)) v = longint'(base_lo);
            else if (v > longint'(base_hi)) v = longint'(base_hi);
            angle[0] = v[ANGLE_W-1:0];
            v = longint'(angle[1]) + sa;
            if (v < 0) v = 0;
            else if (v > longint'(arm_hi)) v = longint'(arm_hi);
            angle[1] = v[ANGLE_W-1:0];
            res.base = angle[0];
            res.arm  = angle[1];
            pending_angles.push_back(res);
        endfunction

        function void check_angles(logic [ANGLE_W-1:0] base, logic [ANGLE_W-1:0] arm);
            t_angles exp_a;
            if (pending_angles.size() == 0) begin
                $error("result word with no tick pending: base %0d arm %0d", base, arm);
                errors++;
                return;
            end
            exp_a = pending_angles.pop_front();
            checked++;
            if (base !== exp_a.base) begin
                $error("base_angle_out expected %0d actual %0d", exp_a.base, base);
                errors++;
            end
            if (arm !== exp_a.arm) begin
                $error("arm_angle_out expected %0d actual %0d", exp_a.arm, arm);
                errors++;
            end
        endfunction

        function int pending();
            return pending_angles.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tapat_in_if  in_if ();
    tapat_out_if out_if ();
    tapat_cfg_if cfg_if ();

    two_axis_pid_angle_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    tracker_mirror mirror;
    int            send_idle;
    int            recv_idle;
    int            hold_reqs;
    int            cycles;
    int            n_settings;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("two_axis_pid_angle_tracker: mismatch");
            $finish;
        end
    end

    // result side, long hold-offs counted here
    initial begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                mirror.check_angles(out_if.base_angle_out, out_if.arm_angle_out);
            if (hold_reqs != holds_seen) begin
                holds_seen = hold_reqs;
                hold_left  = LONG_HOLD;
            end
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_errors(input logic [ERR_W-1:0] x, input logic [ERR_W-1:0] y);
        while ($urandom_range(99) < send_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.x_error <= x;
        in_if.y_error <= y;
        do @(posedge i_clk); while (!in_if.ready);
        mirror.note_errors(x, y);
    endtask

    task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        mirror.set_reg(idx, val);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (TICK_LATENCY) @(posedge i_clk);
    endtask

    task automatic load_settings(input t_settings s);
        write_reg(REG_GAIN_PROP,    {1'b0, s.kp});
        write_reg(REG_GAIN_INTEG,   {1'b0, s.ki});
        write_reg(REG_GAIN_DERIV,   {1'b0, s.kd});
        write_reg(REG_MAX_STEP,     {1'b0, s.max_step});
        write_reg(REG_SMOOTH_ALPHA, {1'b0, s.alpha});
        write_reg(REG_BASE_MIN,     s.base_lo);
        write_reg(REG_BASE_MAX,     s.base_hi);
        write_reg(REG_ARM_MAX,      s.arm_hi);
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    function automatic t_settings random_settings();
        t_settings s;
        int unsigned r, a, b;
        if ($urandom_range(1) == 1) begin
            r = $urandom_range(1023) - 512; s.kp = r[15:0];
            r = $urandom_range(63) - 32;    s.ki = r[15:0];
            r = $urandom_range(8191) - 4096; s.kd = r[15:0];
        end else begin
            r = $urandom(); s.kp = r[15:0];
            r = $urandom(); s.ki = r[15:0];
            r = $urandom(); s.kd = r[15:0];
        end
        r = ($urandom_range(1) == 1) ? $urandom_range(4096) : $urandom();
        s.max_step = r[15:0];
        case ($urandom_range(7))
            0:       r = 0;
            1:       r = 65535;
            default: r = $urandom();
        endcase
        s.alpha = r[15:0];
        a = $urandom_range(69120);
        b = $urandom_range(69120);
        if ($urandom_range(3) != 0 && a > b) begin
            r = a; a = b; b = r;
        end
        s.base_lo = a[ANGLE_W-1:0];
        s.base_hi = b[ANGLE_W-1:0];
        r = $urandom_range(69120);
        s.arm_hi = r[ANGLE_W-1:0];
        return s;
    endfunction

    function automatic logic [ERR_W-1:0] pick_error();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) begin
            r = $urandom_range(32768) - 16384;
        end else if (r < 75) begin
            case ($urandom_range(4))
                0:       r = 32'hFFFF_8000;
                1:       r = 32'hFFFF_C000;
                2:       r = 0;
                3:       r = 16384;
                default: r = 32767;
            endcase
        end else begin
            r = $urandom();
        end
        return r[ERR_W-1:0];
    endfunction

    initial begin
        logic [31:0]        corner_pairs [10];
        t_settings          hi_corner, lo_corner;
        logic [ERR_W-1:0]   cx, cy, x, y;
        int                 run_left;
        int unsigned        r;

        corner_pairs = '{32'h0000_0000, 32'h4000_4000, 32'hC000_C000, 32'h7FFF_8000,
                         32'h8000_7FFF, 32'h4000_C000, 32'hC000_4000, 32'h0001_FFFF,
                         32'h0000_8000, 32'h8000_0000};
        hi_corner = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                      17'd0, 17'd69120, 17'd69120};
        lo_corner = '{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000,
                      17'd69120, 17'd0, 17'd0};

        mirror = new();
        mirror.clear();
        n_settings = 1;
        send_idle  = 0;
        recv_idle  = 0;
        hold_reqs  = 0;
        run_left   = 0;
        cx = '0;
        cy = '0;

        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.x_error <= '0;
        in_if.y_error <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: arm starts above its window
        for (int i = 0; i < 10; i++)
            send_errors(corner_pairs[i][31:16], corner_pairs[i][15:0]);
        drain();
        load_settings(hi_corner);
        for (int i = 0; i < 6; i++)
            send_errors(corner_pairs[i][31:16], corner_pairs[i][15:0]);
        drain();
        // inverted base window, zero step and zero alpha
        load_settings(lo_corner);
        for (int i = 0; i < 6; i++)
            send_errors(corner_pairs[i][31:16], corner_pairs[i][15:0]);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            load_settings(random_settings());
            send_idle = (ph < 3) ? 27 : (ph < 6) ? 59 : 0;
            recv_idle = (ph < 3) ? 59 : (ph < 6) ? 27 : 0;
            if (ph == 1 || ph == 4) hold_reqs++;
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                if (ph == 2 && k == TICKS_PER_PHASE / 2) begin
                    in_if.valid <= 1'b0;
                    while (mirror.pending() != 0) @(posedge i_clk);
                end
                // runs of steady error so the integral builds up, with noise on top
                if (run_left == 0) begin
                    run_left = $urandom_range(24, 1);
                    cx = pick_error();
                    cy = pick_error();
                end
                run_left--;
                x = cx;
                y = cy;
                if ($urandom_range(1) == 1) begin
                    r = $urandom_range(64) - 32;
                    x = cx + r[ERR_W-1:0];
                    r = $urandom_range(64) - 32;
                    y = cy + r[ERR_W-1:0];
                end
                if ($urandom_range(19) == 0) begin
                    x = pick_error();
                    y = pick_error();
                end
                send_errors(x, y);
            end
        end

        drain();
        $display("%0d ticks checked over %0d register settings, with idle mixes on both sides",
                 mirror.checked, n_settings);
        $display("and long result stalls that backed up the error input");
        if (mirror.errors == 0) begin
            $display("two_axis_pid_angle_tracker: match");
        end else begin
            $display("two_axis_pid_angle_tracker: mismatch");
        end
        $finish;
    end

endmodule
